### sv/m3h_pkg.sv
// shared constants, types and helper functions for the murmur3 hash block
package m3h_pkg;

  // mixing constants
  localparam logic [31:0] KEY_MUL_A = 32'hcc9e2d51;
  localparam logic [31:0] KEY_MUL_B = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD  = 32'he6546b64;
  localparam logic [31:0] FIN_MUL_A = 32'h85ebca6b;
  localparam logic [31:0] FIN_MUL_B = 32'hc2b2ae35;

  // rotate and shift amounts
  localparam int unsigned ROT_KEY   = 15;
  localparam int unsigned ROT_FOLD  = 13;
  localparam int unsigned SHR_MIX_A = 16;
  localparam int unsigned SHR_MIX_B = 13;

  // bytes in a full word
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // controller states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_KEY_A = 7'b0000010,
    ST_KEY_B = 7'b0000100,
    ST_MIX   = 7'b0001000,
    ST_FIN_A = 7'b0010000,
    ST_FIN_B = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } m3h_state_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_KEY_A,
    OP_KEY_B,
    OP_MIX,
    OP_FIN_A,
    OP_FIN_B,
    OP_EMIT
  } m3h_op_t;

  // controller to datapath
  typedef struct packed {
    m3h_op_t op;
  } m3h_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } m3h_status_t;

  // rotate left by a constant amount
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // zero the bytes above the valid count of a final word
  function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
    logic [31:0] m;
    case (cnt) inside
      3'd0:         m = 32'h0000_0000;
      3'd1:         m = 32'h0000_00ff;
      3'd2:         m = 32'h0000_ffff;
      3'd3:         m = 32'h00ff_ffff;
      default:      m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

### sv/m3h_in_if.sv
// input channel: message words with byte count and last flag
interface m3h_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

### sv/m3h_out_if.sv
// result channel: finalized hash values
interface m3h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

### sv/m3h_datapath.sv
// hash datapath: word capture, shared multiplier, accumulator and output register
module m3h_datapath import m3h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  m3h_cmd_t    cmd,
  output m3h_status_t status,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  logic [31:0] k_r, k_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] total_r, total_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        full_r, full_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] fold_x, fold_r13, fin_t, total_sum;
  logic        in_full;

  // shared multiplier operand selection
  always_comb begin
    fin_t = h_r ^ total_r;
    case (cmd.op)
      OP_KEY_A: begin
        mul_a = k_r;
        mul_b = KEY_MUL_A;
      end
      OP_KEY_B: begin
        mul_a = rotl32(k_r, ROT_KEY);
        mul_b = KEY_MUL_B;
      end
      OP_FIN_A: begin
        mul_a = fin_t ^ (fin_t >> SHR_MIX_A);
        mul_b = FIN_MUL_A;
      end
      OP_FIN_B: begin
        mul_a = h_r ^ (h_r >> SHR_MIX_B);
        mul_b = FIN_MUL_B;
      end
      default: begin
        mul_a = k_r;
        mul_b = FIN_MUL_B;
      end
    endcase
  end

  assign prod = 32'(mul_a * mul_b);

  // fold step: xor; for a full word also rotate, times five plus constant
  assign fold_x    = h_r ^ k_r;
  assign fold_r13  = rotl32(fold_x, ROT_FOLD);
  assign total_sum = total_r + {29'd0, cnt_r};
  assign in_full   = !in_last || (in_byte_count >= FULL_BYTES);

  // next-state of the datapath registers
  always_comb begin
    k_nxt         = k_r;
    h_nxt         = h_r;
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    full_nxt      = full_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      OP_LOAD: begin
        k_nxt    = in_full ? in_data_word : (in_data_word & tail_mask(in_byte_count));
        cnt_nxt  = in_full ? FULL_BYTES : in_byte_count;
        full_nxt = in_full;
        last_nxt = in_last;
      end
      OP_KEY_A, OP_KEY_B: begin
        k_nxt = prod;
      end
      OP_MIX: begin
        h_nxt     = full_r ? ((fold_r13 << 2) + fold_r13 + FOLD_ADD) : fold_x;
        total_nxt = total_sum;
      end
      OP_FIN_A, OP_FIN_B: begin
        h_nxt = prod;
      end
      OP_EMIT: begin
        out_hash_nxt  = h_r ^ (h_r >> SHR_MIX_A);
        out_valid_nxt = 1'b1;
        h_nxt         = '0;
        total_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      h_r         <= h_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    full_r     <= full_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_hash_value  = out_hash_r;

  // accumulator and length clear once a hash is emitted
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |=> h_r == '0 && total_r == '0)
    else $error("hash state not cleared after emit");

  // emit never overwrites a result still waiting on the output
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> status.out_free)
    else $error("emit while output register busy");

  // a partial word is only ever mixed as the last word of a message
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_MIX && !full_r |-> last_r)
    else $error("partial word mixed without last flag");

endmodule

### sv/m3h_ctrl.sv
// controller state machine sequencing the hash datapath
module m3h_ctrl import m3h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  m3h_status_t status,
  output m3h_cmd_t    cmd
);

  m3h_state_t state_r, state_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_KEY_A;
        end
      end
      ST_KEY_A: begin
        cmd.op    = OP_KEY_A;
        state_nxt = ST_KEY_B;
      end
      ST_KEY_B: begin
        cmd.op    = OP_KEY_B;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.op    = OP_MIX;
        state_nxt = status.last ? ST_FIN_A : ST_IDLE;
      end
      ST_FIN_A: begin
        cmd.op    = OP_FIN_A;
        state_nxt = ST_FIN_B;
      end
      ST_FIN_B: begin
        cmd.op    = OP_FIN_B;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // an accepted transaction always starts key mixing next
  a_accept_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_KEY_A)
    else $error("accepted transaction did not start key mixing");

  // a stalled result holds the sequencer in emit
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && !status.out_free |=> state_r == ST_EMIT)
    else $error("emit left while output busy");

  // a non-final word returns to idle right after mixing
  a_mix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX && !status.last |=> state_r == ST_IDLE)
    else $error("non-final word entered finalization");

endmodule

### sv/murmur3_32_hash_stream.sv
// murmur3 x86 32-bit streaming hash (seed zero): controller plus datapath
// a non-final word passes through the load, key A, key B and mix states before the next can be accepted
// a final word then passes through finalize A, finalize B and emit; the hash appears in the cycle after emit
// the rate is set by one shared 32x32 multiplier used by four sequential steps
// an unconsumed result holds the sequencer in the emit step, so no new word is accepted meanwhile
// synchronous active-low reset clears the hash, the length and the output valid
module murmur3_32_hash_stream import m3h_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  m3h_in_if.sink    in_if,
  m3h_out_if.source out_if
);

  m3h_cmd_t    cmd;
  m3h_status_t status;
  logic        ctl_in_ready;

  // sequencer
  m3h_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (ctl_in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  m3h_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_data_word   (in_if.data_word),
    .in_byte_count  (in_if.byte_count),
    .in_last        (in_if.last),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_hash_value (out_if.hash_value)
  );

  assign in_if.ready = ctl_in_ready;

endmodule

### bench/murmur3_32_hash_stream_check.sv
// checker for the murmur3 stream hash: predicts each message hash and compares results
module murmur3_32_hash_stream_check import m3h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  m3h_in_if           in_ch,
  m3h_out_if          out_ch,
  output int unsigned error_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  // running hash and byte length of the message in flight
  logic [31:0] run_hash;
  logic [31:0] run_length;
  logic [31:0] expected_hashes[$];
  int unsigned mismatches = 0;

  // key scramble: multiply, rotate left by 15, multiply
  function automatic logic [31:0] scramble_key(input logic [31:0] k);
    logic [31:0] t;
    t = k * KEY_MUL_A;
    t = {t[16:0], t[31:17]};
    return t * KEY_MUL_B;
  endfunction

  // fold one full block: xor, rotate left by 13, times 5 plus offset
  function automatic logic [31:0] absorb_block(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] t;
    t = h ^ scramble_key(w);
    t = {t[18:0], t[31:19]};
    return t * 32'd5 + FOLD_ADD;
  endfunction

  // final avalanche of the hash
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> SHR_MIX_A);
    t = t * FIN_MUL_A;
    t = t ^ (t >> SHR_MIX_B);
    t = t * FIN_MUL_B;
    return t ^ (t >> SHR_MIX_A);
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s hash_value expected %08h actual %08h", $realtime, what, want, got);
  endfunction

  // track both channels on every clock edge
  always @(posedge clk) begin : track
    logic [2:0]  n;
    logic [31:0] h;
    logic [31:0] keep;
    if (!rst_n) begin
      run_hash = '0;
      run_length = '0;
      expected_hashes.delete();
    end else begin
      // result transaction: compare with the oldest expected hash
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hashes.size() == 0)
          note_mismatch("unexpected result,", 'x, out_ch.hash_value);
        else begin
          h = expected_hashes.pop_front();
          if (out_ch.hash_value !== h)
            note_mismatch("wrong result,", h, out_ch.hash_value);
        end
      end
      // word transaction: advance the running hash or finish the message
      if (in_ch.valid && in_ch.ready) begin
        n = (in_ch.byte_count > FULL_BYTES) ? FULL_BYTES : in_ch.byte_count;
        if (!in_ch.last) begin
          // non-final words always count as full blocks
          run_hash = absorb_block(run_hash, in_ch.data_word);
          run_length = run_length + 32'(FULL_BYTES);
        end else begin
          h = run_hash;
          if (n == FULL_BYTES)
            h = absorb_block(h, in_ch.data_word);
          else if (n != 3'd0) begin
            // partial tail: upper bytes cleared, scrambled and xored only
            keep = ~(32'hffff_ffff << {n, 3'b000});
            h = h ^ scramble_key(in_ch.data_word & keep);
          end
          h = h ^ (run_length + 32'(n));
          expected_hashes.push_back(avalanche(h));
          run_hash = '0;
          run_length = '0;
        end
      end
    end
    error_count <= mismatches;
    pending <= expected_hashes.size();
  end

endmodule

### bench/murmur3_32_hash_stream_test.sv
// top of the murmur3 stream hash bench: clock, reset, word and result traffic, verdict
module murmur3_32_hash_stream_test import m3h_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_WORDS = 1750;
  localparam int unsigned MAX_IDLE    = 13;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned WATCHDOG    = 500000;

  logic        clk;
  logic        rst_n;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned failures;
  int unsigned pending;

  m3h_in_if  in_ch();
  m3h_out_if out_ch();

  murmur3_32_hash_stream u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  murmur3_32_hash_stream_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .error_count (failures),
    .pending     (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // data word: mostly random, sometimes all zeros or all ones
  function automatic logic [31:0] pick_data();
    case ($urandom_range(9, 0))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one word transaction, preceded by a random gap when gaps are on
  task automatic send_word(input logic [31:0] word, input logic [2:0] count, input logic fin);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(MAX_IDLE, 0) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_word  <= word;
    in_ch.byte_count <= count;
    in_ch.last       <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // whole message: full blocks (with the odd stray count) and a tail word
  task automatic send_message(input int unsigned words);
    logic [2:0] count;
    for (int unsigned i = 1; i < words; i++) begin
      count = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 0)) : FULL_BYTES;
      send_word(pick_data(), count, 1'b0);
    end
    count = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    send_word(pick_data(), count, 1'b1);
  endtask

  // stop offering words until every expected hash has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls plus two long hold-offs
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    out_ch.ready <= 1'b0;
    taken = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken == 6 || taken == 150)
        hold = LONG_HOLD;
      else
        hold = rx_stalls_on ? $urandom_range(MAX_IDLE, 0) : 0;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // word side and verdict
  initial begin : word_source
    int unsigned target;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_word  <= '0;
    in_ch.byte_count <= '0;
    in_ch.last       <= 1'b0;
    tx_gaps_on       = 1'b1;
    rx_stalls_on     = 1'b1;
    items_sent       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message and single-word tails of every length
    send_word(32'hdead_beef, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'hffff_ffff, FULL_BYTES, 1'b1);
    send_word(32'h0000_0000, FULL_BYTES, 1'b1);
    // byte counts above four act as four
    send_word(32'h8000_0001, 3'd5, 1'b1);
    send_word(32'h7fff_fffe, 3'd6, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    // full blocks then a partial tail
    send_word(32'hffff_ffff, FULL_BYTES, 1'b0);
    send_word(32'h0000_0000, FULL_BYTES, 1'b0);
    send_word(32'h1234_5678, 3'd3, 1'b1);
    // short counts on non-final words still count as full blocks
    send_word(32'h0000_00ff, 3'd2, 1'b0);
    send_word(32'hcafe_f00d, 3'd0, 1'b0);
    send_word(32'h0f0f_0f0f, 3'd7, 1'b0);
    send_word(32'haaaa_aaaa, 3'd1, 1'b1);
    // empty final word after a block
    send_word(32'h5555_5555, FULL_BYTES, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    drain();

    // random messages in phases of differing idle patterns
    for (int p = 0; p < 4; p++) begin
      tx_gaps_on   = (p == 0 || p == 2);
      rx_stalls_on = (p == 0 || p == 3);
      target = TOTAL_WORDS * (p + 1) / 4;
      while (items_sent < target)
        send_message(($urandom_range(99, 0) < 85) ? $urandom_range(6, 1)
                                                  : $urandom_range(40, 7));
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
